### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the damage tracker.
// Include by bare file name; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/drt_pkg.sv
// Types and constants of the damage rectangle tracker.
// No dependencies; imported by every module of the block.
package drt_pkg;

   localparam int COORD_BITS  = 12;
   localparam int THR_BITS    = 9;
   localparam int STATUS_BITS = 3;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [1:0] OP_MARK  = 2'd0;
   localparam logic [1:0] OP_FULL  = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_MERGED   = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_APPENDED = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_DROPPED  = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FLUSH    = 3'd4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FULL_THRESH   = 2'd2;

   localparam logic [COORD_BITS-1:0] RST_SCREEN_WIDTH  = 12'd320;
   localparam logic [COORD_BITS-1:0] RST_SCREEN_HEIGHT = 12'd240;
   localparam logic [THR_BITS-1:0]   RST_FULL_THRESH   = 9'd128;

   typedef struct packed {
      logic [COORD_BITS-1:0] left;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] width;
      logic [COORD_BITS-1:0] height;
   } rect_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic signed [15:0]  rect_left;
      logic signed [15:0]  rect_top;
      logic signed [15:0]  rect_width;
      logic signed [15:0]  rect_height;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [COORD_BITS-1:0]  out_left;
      logic [COORD_BITS-1:0]  out_top;
      logic [COORD_BITS-1:0]  out_width;
      logic [COORD_BITS-1:0]  out_height;
      logic                   entry_valid;
      logic                   full_refresh;
      logic                   last;
   } rsp_payload_type;

endpackage

### hw/rtl/drt_rect_mem.sv
// Rectangle table storage: one write port, one registered read port.
// Depends on drt_pkg for rect_type.
module drt_rect_mem import drt_pkg::*; #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  rect_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output rect_type          rd_data
);

   rect_type mem [DEPTH];
   rect_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/drt_clip.sv
// Clips a signed request rectangle to the screen and flags empty results.
// Depends on drt_pkg for the request payload and rect_type.
module drt_clip import drt_pkg::*; (
   input  req_payload_type        req,
   input  logic [COORD_BITS-1:0]  scr_width,
   input  logic [COORD_BITS-1:0]  scr_height,
   output rect_type               rect,
   output logic                   empty
);

   typedef struct packed {
      logic signed [19:0] pos;
      logic signed [19:0] len;
   } span_type;

   function automatic span_type clip_span(logic signed [15:0] pos_i,
                                          logic signed [15:0] len_i,
                                          logic [COORD_BITS-1:0] lim_i);
      logic signed [19:0] p0;
      logic signed [19:0] l0;
      logic signed [19:0] lim;
      span_type s;
      p0  = {{4{pos_i[15]}}, pos_i};
      l0  = {{4{len_i[15]}}, len_i};
      lim = {{(20-COORD_BITS){1'b0}}, lim_i};
      if (p0 < 20'sd0) begin
         s.len = l0 + p0;
         s.pos = 20'sd0;
      end else begin
         s.len = l0;
         s.pos = p0;
      end
      if (s.pos + s.len > lim) begin
         s.len = lim - s.pos;
      end
      return s;
   endfunction

   span_type sx;
   span_type sy;

   always_comb begin
      sx = clip_span(req.rect_left, req.rect_width, scr_width);
      sy = clip_span(req.rect_top, req.rect_height, scr_height);
      rect.left   = sx.pos[COORD_BITS-1:0];
      rect.width  = sx.len[COORD_BITS-1:0];
      rect.top    = sy.pos[COORD_BITS-1:0];
      rect.height = sy.len[COORD_BITS-1:0];
      empty = (sx.len <= 20'sd0) || (sy.len <= 20'sd0);
   end

endmodule

### hw/rtl/drt_area.sv
// Dirty area accumulator and full-refresh threshold compare.
// Depends on drt_pkg for coordinate and threshold widths.
module drt_area import drt_pkg::*; #(
   parameter int MAX_RECTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clr,
   input  logic                  smp,
   input  logic [COORD_BITS-1:0] width,
   input  logic [COORD_BITS-1:0] height,
   input  logic [COORD_BITS-1:0] scr_width,
   input  logic [COORD_BITS-1:0] scr_height,
   input  logic [THR_BITS-1:0]   threshold,
   output logic                  over
);

   localparam int CW    = $clog2(MAX_RECTS + 1);
   localparam int PW    = 2 * COORD_BITS;
   localparam int AW    = PW + CW;
   localparam int LW    = PW + THR_BITS;
   localparam int CMPW  = (AW + 8 > LW) ? AW + 8 : LW;

   logic [PW-1:0] prod_ff, prod_in;
   logic          prod_vld_ff;
   logic [AW-1:0] acc_ff, acc_in;
   logic [PW-1:0] scr_ff, scr_in;
   logic [LW-1:0] lim_ff, lim_in;

   always_comb begin
      prod_in = smp ? PW'(width) * PW'(height) : prod_ff;
      scr_in  = PW'(scr_width) * PW'(scr_height);
      lim_in  = LW'(scr_ff) * LW'(threshold);
      if (clr) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + AW'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
      over = CMPW'({acc_ff, 8'b0}) > CMPW'(lim_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= smp;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      scr_ff  <= scr_in;
      lim_ff  <= lim_in;
   end

endmodule

### hw/rtl/dirty_rect_tracker.sv
// Screen damage rectangle tracker, top level: sequencer, config registers, result register.
// Depends on drt_pkg, drt_rect_mem, drt_clip, drt_area and assert_macros.svh.
//
// The block keeps up to MAX_RECTS damage rectangles in a table with one registered read
// port and one write port, never both used in one cycle, and takes one request at a time.
// A dropped mark, a full-screen mark and an empty flush go straight to the result. A mark that
// lands in the table reads and checks each stored rectangle in turn, then merges in place or
// appends or collapses the table to the screen. A flush first compacts the table (checking
// pairs, taking each entry as the first of a pair, moving entries down on each removal),
// then reads and multiplies each entry's area, compares the sum against the full-refresh limit,
// and emits each entry in turn: read, then send. A finished result waits in the output register
// while the next step runs. The table needs no clearing after reset.
`include "assert_macros.svh"

module dirty_rect_tracker import drt_pkg::*; #(
   parameter int MAX_RECTS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_payload_type         req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_payload_type         rsp_payload,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]   csr_wdata
);

   localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CW = $clog2(MAX_RECTS + 1);
   localparam int CX = CW + 1;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_M_RD    = 5'd1;
   localparam logic [4:0] S_M_CHK   = 5'd2;
   localparam logic [4:0] S_M_END   = 5'd3;
   localparam logic [4:0] S_C_START = 5'd4;
   localparam logic [4:0] S_C_LDI   = 5'd5;
   localparam logic [4:0] S_C_RDJ   = 5'd6;
   localparam logic [4:0] S_C_CHK   = 5'd7;
   localparam logic [4:0] S_SH_RD   = 5'd8;
   localparam logic [4:0] S_SH_WR   = 5'd9;
   localparam logic [4:0] S_A_RD    = 5'd10;
   localparam logic [4:0] S_A_MUL   = 5'd11;
   localparam logic [4:0] S_A_NXT   = 5'd12;
   localparam logic [4:0] S_A_CMP   = 5'd13;
   localparam logic [4:0] S_F_RD    = 5'd14;
   localparam logic [4:0] S_F_OUT   = 5'd15;
   localparam logic [4:0] S_SEND    = 5'd16;

   function automatic logic touches(rect_type a, rect_type b);
      logic [COORD_BITS:0] ar;
      logic [COORD_BITS:0] br;
      logic [COORD_BITS:0] ab;
      logic [COORD_BITS:0] bb;
      ar = {1'b0, a.left} + {1'b0, a.width};
      br = {1'b0, b.left} + {1'b0, b.width};
      ab = {1'b0, a.top} + {1'b0, a.height};
      bb = {1'b0, b.top} + {1'b0, b.height};
      return !(ar < {1'b0, b.left} || br < {1'b0, a.left} ||
               ab < {1'b0, b.top} || bb < {1'b0, a.top});
   endfunction

   function automatic rect_type grow(rect_type a, rect_type b);
      logic [COORD_BITS:0]   ar;
      logic [COORD_BITS:0]   br;
      logic [COORD_BITS:0]   ab;
      logic [COORD_BITS:0]   bb;
      logic [COORD_BITS:0]   rgt;
      logic [COORD_BITS:0]   btm;
      rect_type g;
      ar  = {1'b0, a.left} + {1'b0, a.width};
      br  = {1'b0, b.left} + {1'b0, b.width};
      ab  = {1'b0, a.top} + {1'b0, a.height};
      bb  = {1'b0, b.top} + {1'b0, b.height};
      rgt = (ar > br) ? ar : br;
      btm = (ab > bb) ? ab : bb;
      g.left   = (b.left < a.left) ? b.left : a.left;
      g.top    = (b.top < a.top) ? b.top : a.top;
      g.width  = COORD_BITS'(rgt - {1'b0, g.left});
      g.height = COORD_BITS'(btm - {1'b0, g.top});
      return g;
   endfunction

   function automatic rsp_payload_type make_rsp(logic [STATUS_BITS-1:0] st, rect_type r,
                                                logic vld, logic full, logic lst);
      rsp_payload_type p;
      p.status       = st;
      p.out_left     = r.left;
      p.out_top      = r.top;
      p.out_width    = r.width;
      p.out_height   = r.height;
      p.entry_valid  = vld;
      p.full_refresh = full;
      p.last         = lst;
      return p;
   endfunction

   logic [4:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [IW-1:0]         i_ff, i_in;
   logic [IW-1:0]         j_ff, j_in;
   logic [IW-1:0]         k_ff, k_in;
   rect_type              r_ff, r_in;
   rect_type              a_ff, a_in;
   rsp_payload_type       res_ff, res_in;
   logic                  full_ff, full_in;
   logic                  exact_ff, exact_in;
   logic [COORD_BITS-1:0] sw_ff, sw_in;
   logic [COORD_BITS-1:0] sh_ff, sh_in;
   logic [THR_BITS-1:0]   thr_ff, thr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic                  mem_we;
   logic [IW-1:0]         mem_waddr;
   rect_type              mem_wdata;
   logic                  mem_re;
   logic [IW-1:0]         mem_raddr;
   rect_type              mem_rdata;

   rect_type              clip_rect;
   logic                  clip_empty;
   rect_type              full_rect;
   rect_type              grown;
   logic                  area_clr;
   logic                  area_smp;
   logic                  area_over;
   logic                  out_free;
   logic                  i_more;
   logic                  j_more;
   logic                  k_more;
   logic                  flush_sent;

   drt_rect_mem #(
      .DEPTH  (MAX_RECTS),
      .ADDR_W (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   drt_clip u_clip (
      .req        (req_payload),
      .scr_width  (sw_ff),
      .scr_height (sh_ff),
      .rect       (clip_rect),
      .empty      (clip_empty)
   );

   drt_area #(
      .MAX_RECTS (MAX_RECTS)
   ) u_area (
      .clock      (clock),
      .reset      (reset),
      .clr        (area_clr),
      .smp        (area_smp),
      .width      (mem_rdata.width),
      .height     (mem_rdata.height),
      .scr_width  (sw_ff),
      .scr_height (sh_ff),
      .threshold  (thr_ff),
      .over       (area_over)
   );

   always_comb begin
      full_rect.left   = '0;
      full_rect.top    = '0;
      full_rect.width  = sw_ff;
      full_rect.height = sh_ff;
      out_free = !rsp_valid_ff || rsp_ready;
      i_more   = (CX'(i_ff) + CX'(1)) < CX'(count_ff);
      j_more   = (CX'(j_ff) + CX'(1)) < CX'(count_ff);
      k_more   = (CX'(k_ff) + CX'(2)) < CX'(count_ff);
      flush_sent = (state_ff == S_SEND) && out_free && res_ff.last &&
                   (res_ff.status == ST_FLUSH);
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      r_in      = r_ff;
      a_in      = a_ff;
      res_in    = res_ff;
      full_in   = full_ff;
      exact_in  = exact_ff;
      mem_we    = 1'b0;
      mem_waddr = i_ff;
      mem_wdata = a_ff;
      mem_re    = 1'b0;
      mem_raddr = i_ff;
      area_clr  = 1'b0;
      area_smp  = 1'b0;
      grown     = '0;
      req_ready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_payload.opcode)
                  OP_MARK: begin
                     r_in = clip_rect;
                     i_in = '0;
                     if (clip_empty) begin
                        res_in   = make_rsp(ST_DROPPED, '0, 1'b0, 1'b0, 1'b1);
                        state_in = S_SEND;
                     end else if (count_ff == '0) begin
                        state_in = S_M_END;
                     end else begin
                        state_in = S_M_RD;
                     end
                  end
                  OP_FULL: begin
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     mem_wdata = full_rect;
                     count_in  = CW'(1);
                     res_in    = make_rsp(ST_FULL, full_rect, 1'b1, 1'b0, 1'b1);
                     state_in  = S_SEND;
                  end
                  OP_FLUSH: begin
                     if (count_ff == '0) begin
                        res_in   = make_rsp(ST_FLUSH, '0, 1'b0, 1'b0, 1'b1);
                        state_in = S_SEND;
                     end else begin
                        area_clr = 1'b1;
                        exact_in = 1'b0;
                        i_in     = '0;
                        state_in = S_C_START;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_M_RD: begin
            mem_re    = 1'b1;
            mem_raddr = i_ff;
            state_in  = S_M_CHK;
         end
         S_M_CHK: begin
            if (touches(mem_rdata, r_ff)) begin
               grown     = grow(mem_rdata, r_ff);
               mem_we    = 1'b1;
               mem_waddr = i_ff;
               mem_wdata = grown;
               res_in    = make_rsp(ST_MERGED, grown, 1'b1, 1'b0, 1'b1);
               state_in  = S_SEND;
            end else if (i_more) begin
               i_in     = i_ff + IW'(1);
               state_in = S_M_RD;
            end else begin
               state_in = S_M_END;
            end
         end
         S_M_END: begin
            mem_we = 1'b1;
            if (count_ff < CW'(MAX_RECTS)) begin
               mem_waddr = count_ff[IW-1:0];
               mem_wdata = r_ff;
               count_in  = count_ff + CW'(1);
               res_in    = make_rsp(ST_APPENDED, r_ff, 1'b1, 1'b0, 1'b1);
            end else begin
               mem_waddr = '0;
               mem_wdata = full_rect;
               count_in  = CW'(1);
               res_in    = make_rsp(ST_FULL, full_rect, 1'b1, 1'b0, 1'b1);
            end
            state_in = S_SEND;
         end
         S_C_START: begin
            if (i_more) begin
               mem_re    = 1'b1;
               mem_raddr = i_ff;
               state_in  = S_C_LDI;
            end else begin
               i_in     = '0;
               state_in = S_A_RD;
            end
         end
         S_C_LDI: begin
            a_in     = mem_rdata;
            j_in     = i_ff + IW'(1);
            state_in = S_C_RDJ;
         end
         S_C_RDJ: begin
            mem_re    = 1'b1;
            mem_raddr = j_ff;
            state_in  = S_C_CHK;
         end
         S_C_CHK: begin
            if (touches(a_ff, mem_rdata)) begin
               mem_we    = 1'b1;
               mem_waddr = i_ff;
               mem_wdata = grow(a_ff, mem_rdata);
               k_in      = j_ff;
               if (j_more) begin
                  state_in = S_SH_RD;
               end else begin
                  count_in = count_ff - CW'(1);
                  i_in     = '0;
                  state_in = S_C_START;
               end
            end else if (j_more) begin
               j_in     = j_ff + IW'(1);
               state_in = S_C_RDJ;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = S_C_START;
            end
         end
         S_SH_RD: begin
            mem_re    = 1'b1;
            mem_raddr = k_ff + IW'(1);
            state_in  = S_SH_WR;
         end
         S_SH_WR: begin
            mem_we    = 1'b1;
            mem_waddr = k_ff;
            mem_wdata = mem_rdata;
            if (k_more) begin
               k_in     = k_ff + IW'(1);
               state_in = S_SH_RD;
            end else begin
               count_in = count_ff - CW'(1);
               i_in     = '0;
               state_in = S_C_START;
            end
         end
         S_A_RD: begin
            mem_re    = 1'b1;
            mem_raddr = i_ff;
            state_in  = S_A_MUL;
         end
         S_A_MUL: begin
            area_smp = 1'b1;
            if (count_ff == CW'(1) && mem_rdata.width == sw_ff &&
                mem_rdata.height == sh_ff) begin
               exact_in = 1'b1;
            end
            state_in = S_A_NXT;
         end
         S_A_NXT: begin
            if (i_more) begin
               i_in     = i_ff + IW'(1);
               state_in = S_A_RD;
            end else begin
               state_in = S_A_CMP;
            end
         end
         S_A_CMP: begin
            full_in  = exact_ff || area_over;
            i_in     = '0;
            state_in = S_F_RD;
         end
         S_F_RD: begin
            mem_re    = 1'b1;
            mem_raddr = i_ff;
            state_in  = S_F_OUT;
         end
         S_F_OUT: begin
            res_in = make_rsp(ST_FLUSH, mem_rdata, 1'b1, full_ff, !i_more);
            if (!i_more) begin
               count_in = '0;
            end
            state_in = S_SEND;
         end
         S_SEND: begin
            if (out_free) begin
               if (res_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = S_F_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (state_ff == S_SEND && out_free) begin
         rsp_payload_in = res_ff;
         rsp_valid_in   = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      sw_in  = sw_ff;
      sh_in  = sh_ff;
      thr_in = thr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  sw_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: sh_in  = csr_wdata;
            CSR_FULL_THRESH:   thr_in = csr_wdata[THR_BITS-1:0];
            default: begin
               sw_in = sw_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sw_ff        <= RST_SCREEN_WIDTH;
         sh_ff        <= RST_SCREEN_HEIGHT;
         thr_ff       <= RST_FULL_THRESH;
         full_ff      <= 1'b0;
         exact_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         sw_ff        <= sw_in;
         sh_ff        <= sh_in;
         thr_ff       <= thr_in;
         full_ff      <= full_in;
         exact_ff     <= exact_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff           <= i_in;
      j_ff           <= j_in;
      k_ff           <= k_in;
      r_ff           <= r_in;
      a_ff           <= a_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CW'(MAX_RECTS))
   `ASSERT_ALWAYS(a_one_table_access, clock, reset, !(mem_we && mem_re))
   `ASSERT_NEXT(a_flush_empties, clock, reset, flush_sent, count_ff == '0)
   `ASSERT_IMPLY(a_rsp_from_send, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_SEND)

endmodule

### verif/drt_result_checker.sv
`timescale 1ns / 1ps
// Checker for the damage rectangle tracker: tracks the rectangle table and screen registers,
// predicts the results of every request transfer and compares the result channel against them.
// Depends on drt_pkg; instantiated by tb_dirty_rect_tracker beside the block.
module drt_result_checker import drt_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  req_payload_type         req_payload,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rsp_payload_type         rsp_payload,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]   csr_wdata,
   output int                      outstanding,
   output int                      checked_count,
   output int                      fail_count
);

   localparam int RECT_SLOTS = 8;

   typedef struct {
      int x;
      int y;
      int w;
      int h;
   } damage_type;

   typedef longint unsigned area_type;

   damage_type            rects [RECT_SLOTS];
   int                    rect_total;
   logic [COORD_BITS-1:0] scr_w;
   logic [COORD_BITS-1:0] scr_h;
   logic [THR_BITS-1:0]   thresh;
   rsp_payload_type       due_results [$];

   function automatic bit rects_touch(damage_type a, damage_type b);
      return !(a.x + a.w < b.x || b.x + b.w < a.x || a.y + a.h < b.y || b.y + b.h < a.y);
   endfunction

   function automatic damage_type rect_union(damage_type a, damage_type b);
      damage_type u;
      int         right;
      int         bottom;
      right  = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
      bottom = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
      u.x = (b.x < a.x) ? b.x : a.x;
      u.y = (b.y < a.y) ? b.y : a.y;
      u.w = right - u.x;
      u.h = bottom - u.y;
      return u;
   endfunction

   function automatic void collapse_to_screen();
      rects[0] = '{0, 0, int'(scr_w), int'(scr_h)};
      rect_total = 1;
   endfunction

   function automatic void push_result(logic [STATUS_BITS-1:0] st, damage_type b,
                                       logic valid, logic full, logic last);
      rsp_payload_type e;
      e.status       = st;
      e.out_left     = b.x[COORD_BITS-1:0];
      e.out_top      = b.y[COORD_BITS-1:0];
      e.out_width    = b.w[COORD_BITS-1:0];
      e.out_height   = b.h[COORD_BITS-1:0];
      e.entry_valid  = valid;
      e.full_refresh = full;
      e.last         = last;
      due_results.insert(due_results.size(), e);
   endfunction

   task automatic track_request(input req_payload_type p);
      damage_type r;
      damage_type none;
      int         sw;
      int         sh;
      int         i;
      int         j;
      int         k;
      bit         hit;
      bit         again;
      bit         full_adv;
      area_type   area;
      area_type   area_limit;
      none = '{0, 0, 0, 0};
      sw = int'(scr_w);
      sh = int'(scr_h);
      case (p.opcode)
         OP_MARK: begin
            r.x = int'($signed(p.rect_left));
            r.y = int'($signed(p.rect_top));
            r.w = int'($signed(p.rect_width));
            r.h = int'($signed(p.rect_height));
            if (r.x < 0) begin
               r.w += r.x;
               r.x = 0;
            end
            if (r.y < 0) begin
               r.h += r.y;
               r.y = 0;
            end
            if (r.x + r.w > sw) r.w = sw - r.x;
            if (r.y + r.h > sh) r.h = sh - r.y;
            if (r.w <= 0 || r.h <= 0) begin
               push_result(ST_DROPPED, none, 1'b0, 1'b0, 1'b1);
            end else begin
               hit = 1'b0;
               for (i = 0; i < rect_total && !hit; i++) begin
                  if (rects_touch(rects[i], r)) begin
                     rects[i] = rect_union(rects[i], r);
                     push_result(ST_MERGED, rects[i], 1'b1, 1'b0, 1'b1);
                     hit = 1'b1;
                  end
               end
               if (!hit && rect_total < RECT_SLOTS) begin
                  rects[rect_total] = r;
                  rect_total++;
                  push_result(ST_APPENDED, r, 1'b1, 1'b0, 1'b1);
               end else if (!hit) begin
                  collapse_to_screen();
                  push_result(ST_FULL, rects[0], 1'b1, 1'b0, 1'b1);
               end
            end
         end
         OP_FULL: begin
            collapse_to_screen();
            push_result(ST_FULL, rects[0], 1'b1, 1'b0, 1'b1);
         end
         OP_FLUSH: begin
            if (rect_total == 0) begin
               push_result(ST_FLUSH, none, 1'b0, 1'b0, 1'b1);
            end else begin
               // merge touching pairs until none remain, closing gaps in table order
               again = 1'b1;
               while (again && rect_total > 1) begin
                  again = 1'b0;
                  for (i = 0; i < rect_total && !again; i++) begin
                     for (j = i + 1; j < rect_total; j++) begin
                        if (rects_touch(rects[i], rects[j])) begin
                           rects[i] = rect_union(rects[i], rects[j]);
                           for (k = j; k + 1 < rect_total; k++) rects[k] = rects[k + 1];
                           rect_total--;
                           again = 1'b1;
                           break;
                        end
                     end
                  end
               end
               if (rect_total == 1 && rects[0].w == sw && rects[0].h == sh) begin
                  full_adv = 1'b1;
               end else begin
                  area = 0;
                  for (i = 0; i < rect_total; i++)
                     area += area_type'(rects[i].w) * area_type'(rects[i].h);
                  area_limit = area_type'(sw) * area_type'(sh) * area_type'(thresh);
                  full_adv = (area * 256 > area_limit);
               end
               for (i = 0; i < rect_total; i++)
                  push_result(ST_FLUSH, rects[i], 1'b1, full_adv, i + 1 == rect_total);
               rect_total = 0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rect_total    = 0;
         scr_w         = RST_SCREEN_WIDTH;
         scr_h         = RST_SCREEN_HEIGHT;
         thresh        = RST_FULL_THRESH;
         checked_count = 0;
         fail_count    = 0;
         due_results.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  scr_w  = csr_wdata;
               CSR_SCREEN_HEIGHT: scr_h  = csr_wdata;
               CSR_FULL_THRESH:   thresh = csr_wdata[THR_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: result transfer mismatch, expected none, actual %h",
                        $time, rsp_payload);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               checked_count++;
               check_field("status", 16'(want.status), 16'(rsp_payload.status));
               check_field("out_left", 16'(want.out_left), 16'(rsp_payload.out_left));
               check_field("out_top", 16'(want.out_top), 16'(rsp_payload.out_top));
               check_field("out_width", 16'(want.out_width), 16'(rsp_payload.out_width));
               check_field("out_height", 16'(want.out_height),
                           16'(rsp_payload.out_height));
               check_field("entry_valid", 16'(want.entry_valid),
                           16'(rsp_payload.entry_valid));
               check_field("full_refresh", 16'(want.full_refresh),
                           16'(rsp_payload.full_refresh));
               check_field("last", 16'(want.last), 16'(rsp_payload.last));
            end
         end
         if (req_valid && req_ready) track_request(req_payload);
      end
      outstanding <= due_results.size();
   end

endmodule

### verif/tb_dirty_rect_tracker.sv
`timescale 1ns / 1ps
// Testbench top for the damage rectangle tracker: drives request transfers, screen register
// writes and result back-pressure, and gives the verdict.
// Depends on drt_pkg, drt_result_checker and the dirty_rect_tracker RTL.
module tb_dirty_rect_tracker;
   import drt_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         CYCLE_LIMIT  = 1_000_000;
   localparam int         DRAIN_CYCLES = 600;
   localparam int         HOLD_CYCLES  = 400;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   req_payload_type         req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   rsp_payload_type         rsp_payload;
   logic                    csr_wr_en   = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index   = '0;
   logic [COORD_BITS-1:0]   csr_wdata   = '0;

   int outstanding;
   int checked_count;
   int fail_count;
   int sent_count  = 0;
   int send_calm   = 0;
   int rsp_run     = 0;
   int rsp_stall   = 0;
   int cycle_count = 0;
   int cur_w       = RST_SCREEN_WIDTH;
   int cur_h       = RST_SCREEN_HEIGHT;
   bit no_gaps     = 1'b0;
   bit hold_rsp    = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dirty_rect_tracker i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   drt_result_checker i_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .csr_wr_en, .csr_index, .csr_wdata,
      .outstanding, .checked_count, .fail_count
   );

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   task automatic send(logic [1:0] op, int l, int t, int w, int h);
      req_payload_type p;
      int              gap;
      gap = pick_gap();
      if (send_calm > 0) begin
         send_calm--;
         gap = 0;
      end else if ($urandom_range(0, 39) == 0) begin
         send_calm = 30;
      end
      if (no_gaps) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      p.opcode      = op;
      p.rect_left   = l[15:0];
      p.rect_top    = t[15:0];
      p.rect_width  = w[15:0];
      p.rect_height = h[15:0];
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_ready !== 1'b1);
      sent_count++;
   endtask

   task automatic send_random();
      int roll;
      int x;
      int y;
      int w;
      int h;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         send(OP_FLUSH, $urandom(), $urandom(), $urandom(), $urandom());
      end else if (roll < 11) begin
         send(OP_FULL, $urandom(), $urandom(), $urandom(), $urandom());
      end else if (roll < 14) begin
         send(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(), $urandom());
      end else if (roll < 22) begin
         send(OP_MARK, $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
         w = $urandom_range(1, cur_w / 6 + 2);
         h = $urandom_range(1, cur_h / 6 + 2);
         x = $urandom_range(0, cur_w + 8) - 8;
         y = $urandom_range(0, cur_h + 8) - 8;
         if ($urandom_range(0, 19) == 0) w = -$urandom_range(0, 3);
         if ($urandom_range(0, 19) == 0) h = -$urandom_range(0, 3);
         send(OP_MARK, x, y, w, h);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_screen(int w, int h, int thr);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= w[COORD_BITS-1:0];
      @(posedge clock);
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_wdata <= h[COORD_BITS-1:0];
      @(posedge clock);
      csr_index <= CSR_FULL_THRESH;
      csr_wdata <= thr[COORD_BITS-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_w = w;
      cur_h = h;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d results due", $time, outstanding);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_run > 0) begin
               rsp_run--;
            end else begin
               rsp_run   = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(0, 5);
               rsp_stall = pick_gap();
            end
         end
      end
   end

   initial begin : stimulus
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send(OP_FLUSH, 0, 0, 0, 0);
      send(OP_UNUSED, -1, -1, -1, -1);
      send(OP_MARK, -32768, -32768, 32767, 32767);
      send(OP_MARK, 32767, 32767, 32767, 32767);
      send(OP_MARK, -10, -10, 30, 30);
      send(OP_MARK, 20, 0, 10, 5);
      send(OP_MARK, 100, 100, 0, 10);
      send(OP_MARK, 100, 100, 10, -5);
      send(OP_MARK, 50, 50, 10, 10);
      send(OP_MARK, 60, 60, 5, 5);
      send(OP_MARK, 300, 200, 100, 100);
      send(OP_FLUSH, 0, 0, 0, 0);
      for (n = 0; n < 8; n++) send(OP_MARK, 40 * n, 100, 10, 10);
      send(OP_MARK, 0, 200, 5, 5);
      send(OP_FLUSH, 0, 0, 0, 0);
      send(OP_MARK, 0, 0, 10, 10);
      send(OP_MARK, 20, 0, 10, 10);
      send(OP_MARK, 5, 5, 15, 2);
      send(OP_FLUSH, 0, 0, 0, 0);
      send(OP_MARK, 10, 10, 20, 20);
      drain();

      program_screen(4095, 4095, 256);
      repeat (70) send_random();
      drain();

      program_screen(64, 48, 0);
      repeat (70) send_random();
      drain();

      program_screen(1, 1, 255);
      send(OP_MARK, 0, 0, 1, 1);
      send(OP_MARK, -5, -5, 10, 10);
      send(OP_FLUSH, 0, 0, 0, 0);
      drain();

      program_screen(0, 0, 1);
      send(OP_MARK, 0, 0, 5, 5);
      send(OP_FULL, 0, 0, 0, 0);
      send(OP_FLUSH, 0, 0, 0, 0);
      send(OP_FULL, 0, 0, 0, 0);
      drain();

      program_screen(200, 150, 64);
      no_gaps  = 1'b1;
      hold_rsp = 1'b1;
      repeat (30) send_random();
      no_gaps = 1'b0;
      repeat (70) send_random();
      drain();

      $display("Sent %0d request transfers, checked %0d result transfers, six screen sizes,",
               sent_count, checked_count);
      $display("with clipping, edge and corner merges, table overflow, compaction and long stalls.");
      if (fail_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/drt_pkg.sv
hw/rtl/drt_rect_mem.sv
hw/rtl/drt_clip.sv
hw/rtl/drt_area.sv
hw/rtl/dirty_rect_tracker.sv
verif/drt_result_checker.sv
verif/tb_dirty_rect_tracker.sv
